/* rtl/encoder_calibration_profile_drive_defines.svh */
// assertion macros for the encoder calibration and profile drive block
// used by the top level only, needs clk and rst in scope
`ifndef ENCODER_CALIBRATION_PROFILE_DRIVE_DEFINES_SVH
`define ENCODER_CALIBRATION_PROFILE_DRIVE_DEFINES_SVH

// same-cycle implication
`define ECPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ecpd_pkg.sv */
// shared types, codes and constants of the encoder calibration and profile drive
// no dependencies
package ecpd_pkg;

  localparam int unsigned NUM_W  = 42;  // divider dividend width
  localparam int unsigned DEN_W  = 17;  // divider divisor width
  localparam int unsigned RAD_W  = 52;  // square root radicand width
  localparam int unsigned ROOT_W = 26;

  localparam logic [15:0] STILL_TICKS        = 16'd40;
  localparam logic [16:0] MAX_SYNC_CORR_UM_S = 17'd100000;
  localparam logic [24:0] MISMATCH_SUM_MM    = 25'd400;
  localparam logic [23:0] MAX_MISMATCH_MM    = 24'd100;
  localparam logic [17:0] STOP_TOL_X2_MM     = 18'd40;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RUN    = 2'd1,
    PH_SETTLE = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FLT_NONE     = 2'd0,
    FLT_TIMEOUT  = 2'd1,
    FLT_MISMATCH = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    MD_TICK       = 3'd0,
    MD_START_MAN  = 3'd1,
    MD_STOP_MAN   = 3'd2,
    MD_START_AUTO = 3'd3,
    MD_STOP_AUTO  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    RG_LEFT_CPM   = 3'd0,
    RG_RIGHT_CPM  = 3'd1,
    RG_MAN_DIST   = 3'd2,
    RG_AUTO_DIST  = 3'd3,
    RG_CRUISE     = 3'd4,
    RG_ACCEL      = 3'd5,
    RG_SYNC_GAIN  = 3'd6,
    RG_TIMEOUT    = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_LMUL, SQ_LDIV, SQ_LWAIT, SQ_RMUL, SQ_RDIV, SQ_RWAIT,
    SQ_STILL, SQ_CTRL, SQ_BMUL1, SQ_BMUL2, SQ_SQRT, SQ_SWAIT, SQ_RAMP,
    SQ_CMUL1, SQ_CMUL2, SQ_CORR, SQ_EMIT
  } seq_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } cmd_t;

  typedef struct packed {
    logic               drive_active;
    logic [1:0]         phase;
    logic [1:0]         fault_code;
    logic signed [23:0] left_speed_um_s;
    logic signed [23:0] right_speed_um_s;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;
    logic [31:0]        left_measured_cpm;
    logic [31:0]        right_measured_cpm;
    logic [23:0]        left_travel_mm;
    logic [23:0]        right_travel_mm;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_sts_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_sts_t;

endpackage

/* rtl/ecpd_div.sv */
// restoring divider, one quotient bit per cycle
// depends on ecpd_pkg
module ecpd_div (
  input  logic              clk,
  input  logic              rst,
  input  ecpd_pkg::div_req_t req,
  output ecpd_pkg::div_sts_t sts
);
  import ecpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic             done;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
      rem  <= '0;
      quo  <= req.num;
      den  <= req.den;
    end else begin
      done <= 1'b0;
      if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        rem  <= fits ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
        quo  <= {quo[NUM_W-2:0], fits};
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign sts.done = done;
  assign sts.quo  = quo;

endmodule

/* rtl/ecpd_sqrt.sv */
// digit-by-digit integer square root, one root bit per cycle
// depends on ecpd_pkg
module ecpd_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  ecpd_pkg::sqrt_req_t req,
  output ecpd_pkg::sqrt_sts_t sts
);
  import ecpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic              done;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(ROOT_W);
      done <= 1'b0;
      rad  <= req.rad;
      rem  <= '0;
      root <= '0;
    end else begin
      done <= 1'b0;
      if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        rad  <= {rad[RAD_W-3:0], 2'b00};
        rem  <= fits ? rem_sh - trial : rem_sh;
        root <= {root[ROOT_W-2:0], fits};
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  assign sts.done = done;
  assign sts.root = root;

endmodule

/* rtl/encoder_calibration_profile_drive.sv */
// top level of the encoder calibration and trapezoidal profile drive
// depends on ecpd_pkg, ecpd_div, ecpd_sqrt and encoder_calibration_profile_drive_defines.svh
//
//   channel  direction  handshake            payload
//   cmd      in         cmd_valid/cmd_stall  ecpd_pkg::cmd_t
//   res      out        res_valid/res_stall  ecpd_pkg::res_t
//
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a tick or a stop-manual during a run goes through the two 42-bit divisions, and a
//   profile tick also through the 26-bit square root; no new command is taken meanwhile
// rst is synchronous and restores the configuration registers and clears every run state
// while a result waits on res_stall the next command is still taken; the
//   sequencer only holds in its final step until the output register frees
module encoder_calibration_profile_drive (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  ecpd_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output ecpd_pkg::res_t res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import ecpd_pkg::*;
  `include "encoder_calibration_profile_drive_defines.svh"

  // configuration registers
  logic [15:0] left_cpm_cfg, right_cpm_cfg, man_dist, auto_dist;
  logic [11:0] cruise;
  logic [13:0] accel;
  logic [15:0] sync_gain, timeout;

  // run state
  seq_t        seq, seq_next;
  phase_t      run_phase;
  fault_t      fault_reg;
  logic        auto_selected;
  logic [31:0] left_sum, right_sum;
  logic [31:0] left_cpm_result, right_cpm_result;
  logic [23:0] left_dist, right_dist;
  logic [22:0] profile_speed;
  logic [15:0] still_count, elapsed_count;

  // per-transaction working registers
  logic [2:0]         mode_q;
  logic               ld_zero, rd_zero;
  logic               active_q;
  logic signed [23:0] lsp_q, rsp_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  div_req_t  div_req;
  div_sts_t  div_sts;
  sqrt_req_t sqrt_req;
  sqrt_sts_t sqrt_sts;

  logic cmd_acc;
  logic res_free;
  logic is_cal;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (seq != SQ_IDLE);
  assign cmd_acc   = cmd_valid && (seq == SQ_IDLE);
  assign res_free  = !res_valid || !res_stall;
  assign is_cal    = (mode_q == MD_STOP_MAN);

  // magnitudes of the totals, the most negative value maps to 2^31
  logic [31:0] l_mag, r_mag;
  assign l_mag = left_sum[31]  ? (~left_sum + 32'd1)  : left_sum;
  assign r_mag = right_sum[31] ? (~right_sum + 32'd1) : right_sum;

  // zero counts per metre or zero distance count as one
  logic [15:0] l_c, r_c, d_c;
  assign l_c = (left_cpm_cfg == '0)  ? 16'd1 : left_cpm_cfg;
  assign r_c = (right_cpm_cfg == '0) ? 16'd1 : right_cpm_cfg;
  assign d_c = (man_dist == '0)      ? 16'd1 : man_dist;

  // control decisions on the current distances
  logic [24:0]        sum2;
  logic signed [24:0] diff;
  logic [23:0]        amag;
  logic [15:0]        el_inc, still_inc;
  logic               t_out, mism, at_target;
  logic signed [26:0] tgt2;

  assign sum2      = {1'b0, left_dist} + {1'b0, right_dist};
  assign diff      = $signed({1'b0, left_dist}) - $signed({1'b0, right_dist});
  assign amag      = diff[24] ? 24'(-diff) : diff[23:0];
  assign el_inc    = (elapsed_count == 16'hFFFF) ? elapsed_count : elapsed_count + 16'd1;
  assign still_inc = (still_count == 16'hFFFF) ? still_count : still_count + 16'd1;
  assign t_out     = el_inc >= timeout;
  assign mism      = (sum2 > MISMATCH_SUM_MM) && (amag > MAX_MISMATCH_MM);
  assign tgt2      = $signed({10'b0, auto_dist, 1'b0}) - $signed({9'b0, STOP_TOL_X2_MM});
  assign at_target = $signed({2'b0, sum2}) >= tgt2;

  logic ctrl_live, go_profile;
  assign ctrl_live  = auto_selected && (run_phase == PH_RUN || run_phase == PH_SETTLE);
  assign go_profile = ctrl_live && !t_out && !mism && (run_phase == PH_RUN) && !at_target;

  // profile ramp arithmetic
  logic [21:0]        cruise_um;
  logic [21:0]        desired;
  logic [16:0]        step;
  logic signed [25:0] sp_s, d_s, st_s, sp_new;
  logic [24:0]        brake_span;

  assign cruise_um  = ({cruise, 10'b0}) - ({6'b0, cruise, 4'b0}) - ({7'b0, cruise, 3'b0});
  assign desired    = (sqrt_sts.root < {4'b0, cruise_um}) ? sqrt_sts.root[21:0] : cruise_um;
  assign step       = {1'b0, accel, 2'b0} + {3'b0, accel};
  assign sp_s       = $signed({3'b0, profile_speed});
  assign d_s        = $signed({4'b0, desired});
  assign st_s       = $signed({9'b0, step});
  assign brake_span = {8'b0, auto_dist, 1'b0} - sum2;

  always_comb begin
    if (sp_s < d_s - st_s) begin
      sp_new = sp_s + st_s;
    end else if (sp_s > d_s + st_s) begin
      sp_new = sp_s - st_s;
    end else begin
      sp_new = d_s;
    end
  end

  // sync correction, clamped to half the speed and to the fixed ceiling
  logic [34:0]        cmag;
  logic [16:0]        lim, cm;
  logic               big;
  logic signed [23:0] sp24, cm24;

  assign cmag = 35'((prod[42:0] + 43'd128) >> 8);
  assign big  = (amag[23:16] != '0) && (sync_gain != '0);
  assign lim  = (profile_speed[22:1] > {5'b0, MAX_SYNC_CORR_UM_S}) ?
                MAX_SYNC_CORR_UM_S : profile_speed[17:1];
  assign cm   = (big || cmag > {18'b0, lim}) ? lim : cmag[16:0];
  assign sp24 = $signed({1'b0, profile_speed});
  assign cm24 = $signed({7'b0, cm});

  // next step of the sequencer
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE: begin
        if (cmd_acc) begin
          if (cmd.mode == MD_TICK && (run_phase == PH_RUN || run_phase == PH_SETTLE)) begin
            seq_next = SQ_LMUL;
          end else if (cmd.mode == MD_STOP_MAN && run_phase == PH_RUN) begin
            seq_next = SQ_LMUL;
          end else begin
            seq_next = SQ_EMIT;
          end
        end
      end
      SQ_LMUL:  seq_next = SQ_LDIV;
      SQ_LDIV:  seq_next = SQ_LWAIT;
      SQ_LWAIT: if (div_sts.done) seq_next = SQ_RMUL;
      SQ_RMUL:  seq_next = SQ_RDIV;
      SQ_RDIV:  seq_next = SQ_RWAIT;
      SQ_RWAIT: if (div_sts.done) seq_next = is_cal ? SQ_EMIT : SQ_STILL;
      SQ_STILL: seq_next = SQ_CTRL;
      SQ_CTRL:  seq_next = go_profile ? SQ_BMUL1 : SQ_EMIT;
      SQ_BMUL1: seq_next = SQ_BMUL2;
      SQ_BMUL2: seq_next = SQ_SQRT;
      SQ_SQRT:  seq_next = SQ_SWAIT;
      SQ_SWAIT: if (sqrt_sts.done) seq_next = SQ_RAMP;
      SQ_RAMP:  seq_next = SQ_CMUL1;
      SQ_CMUL1: seq_next = SQ_CMUL2;
      SQ_CMUL2: seq_next = SQ_CORR;
      SQ_CORR:  seq_next = SQ_EMIT;
      SQ_EMIT:  if (res_free) seq_next = SQ_IDLE;
      default:  seq_next = SQ_IDLE;
    endcase
  end

  // operands of the shared units
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    sqrt_req = '0;
    unique case (seq)
      SQ_LMUL, SQ_RMUL: begin
        mul_a = (seq == SQ_LMUL) ? l_mag : r_mag;
        mul_b = is_cal ? 32'd1000 : 32'd2000;
      end
      SQ_LDIV, SQ_RDIV: begin
        div_req.start = 1'b1;
        if (is_cal) begin
          div_req.num = prod[NUM_W-1:0] + {27'b0, d_c[15:1]};
          div_req.den = {1'b0, d_c};
        end else if (seq == SQ_LDIV) begin
          div_req.num = prod[NUM_W-1:0] + {26'b0, l_c};
          div_req.den = {l_c, 1'b0};
        end else begin
          div_req.num = prod[NUM_W-1:0] + {26'b0, r_c};
          div_req.den = {r_c, 1'b0};
        end
      end
      SQ_BMUL1: begin
        mul_a = {18'b0, accel};
        mul_b = {14'b0, brake_span[17:0]};
      end
      SQ_BMUL2: begin
        mul_a = prod[31:0];
        mul_b = 32'd1000000;
      end
      SQ_SQRT: begin
        sqrt_req.start = 1'b1;
        sqrt_req.rad   = prod[RAD_W-1:0];
      end
      SQ_CMUL1: begin
        mul_a = {16'b0, sync_gain};
        mul_b = {16'b0, amag[15:0]};
      end
      SQ_CMUL2: begin
        mul_a = prod[31:0];
        mul_b = 32'd1000;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  ecpd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .sts (div_sts)
  );

  ecpd_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .sts (sqrt_sts)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cpm_cfg  <= 16'd8000;
      right_cpm_cfg <= 16'd8000;
      man_dist      <= 16'd1000;
      auto_dist     <= 16'd4000;
      cruise        <= 12'd500;
      accel         <= 14'd500;
      sync_gain     <= 16'd512;
      timeout       <= 16'd6000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RG_LEFT_CPM:  left_cpm_cfg  <= cfg_data;
        RG_RIGHT_CPM: right_cpm_cfg <= cfg_data;
        RG_MAN_DIST:  man_dist      <= cfg_data;
        RG_AUTO_DIST: auto_dist     <= cfg_data;
        RG_CRUISE:    cruise        <= cfg_data[11:0];
        RG_ACCEL:     accel         <= cfg_data[13:0];
        RG_SYNC_GAIN: sync_gain     <= cfg_data;
        RG_TIMEOUT:   timeout       <= cfg_data;
        default:      timeout       <= timeout;
      endcase
    end
  end

  // sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq              <= SQ_IDLE;
      run_phase        <= PH_IDLE;
      fault_reg        <= FLT_NONE;
      auto_selected    <= 1'b0;
      left_sum         <= '0;
      right_sum        <= '0;
      left_cpm_result  <= '0;
      right_cpm_result <= '0;
      left_dist        <= '0;
      right_dist       <= '0;
      profile_speed    <= '0;
      still_count      <= '0;
      elapsed_count    <= '0;
      res_valid        <= 1'b0;
      active_q         <= 1'b0;
      mode_q           <= MD_TICK;
    end else begin
      seq <= seq_next;
      // result register fills as the sequencer leaves its last step
      if (seq == SQ_EMIT && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (seq)
        SQ_IDLE: begin
          if (cmd_acc) begin
            mode_q   <= cmd.mode;
            ld_zero  <= (cmd.left_delta == '0);
            rd_zero  <= (cmd.right_delta == '0);
            active_q <= 1'b0;
            lsp_q    <= '0;
            rsp_q    <= '0;
            unique case (cmd.mode)
              MD_TICK: begin
                if (run_phase == PH_RUN || run_phase == PH_SETTLE) begin
                  left_sum  <= left_sum - 32'(cmd.left_delta);
                  right_sum <= right_sum + 32'(cmd.right_delta);
                end
              end
              MD_START_MAN, MD_START_AUTO: begin
                run_phase        <= PH_RUN;
                fault_reg        <= FLT_NONE;
                auto_selected    <= (cmd.mode == MD_START_AUTO);
                left_sum         <= '0;
                right_sum        <= '0;
                left_cpm_result  <= '0;
                right_cpm_result <= '0;
                left_dist        <= '0;
                right_dist       <= '0;
                profile_speed    <= '0;
                still_count      <= '0;
                elapsed_count    <= '0;
              end
              MD_STOP_AUTO: begin
                if (auto_selected && (run_phase == PH_RUN || run_phase == PH_SETTLE)) begin
                  profile_speed <= '0;
                  fault_reg     <= FLT_NONE;
                  run_phase     <= PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        SQ_LWAIT, SQ_RWAIT: begin
          if (div_sts.done) begin
            if (is_cal) begin
              if (seq == SQ_LWAIT) begin
                left_cpm_result <= (div_sts.quo[NUM_W-1:32] != '0) ? '1 : div_sts.quo[31:0];
              end else begin
                right_cpm_result <= (div_sts.quo[NUM_W-1:32] != '0) ? '1 : div_sts.quo[31:0];
                run_phase        <= PH_DONE;
              end
            end else if (seq == SQ_LWAIT) begin
              left_dist <= (div_sts.quo[NUM_W-1:24] != '0) ? '1 : div_sts.quo[23:0];
            end else begin
              right_dist <= (div_sts.quo[NUM_W-1:24] != '0) ? '1 : div_sts.quo[23:0];
            end
          end
        end
        SQ_STILL: begin
          // still ticks count only while an auto run settles
          if (auto_selected && run_phase == PH_SETTLE) begin
            if (ld_zero && rd_zero) begin
              still_count <= still_inc;
              if (still_inc >= STILL_TICKS) begin
                profile_speed <= '0;
                fault_reg     <= FLT_NONE;
                run_phase     <= PH_DONE;
              end
            end else begin
              still_count <= '0;
            end
          end
        end
        SQ_CTRL: begin
          if (ctrl_live) begin
            elapsed_count <= el_inc;
            if (t_out) begin
              profile_speed <= '0;
              fault_reg     <= FLT_TIMEOUT;
              run_phase     <= PH_DONE;
            end else if (mism) begin
              profile_speed <= '0;
              fault_reg     <= FLT_MISMATCH;
              run_phase     <= PH_DONE;
            end else if (run_phase == PH_SETTLE) begin
              active_q <= 1'b1;
            end else if (at_target) begin
              // close enough: hold the wheels and wait for stillness
              profile_speed <= '0;
              still_count   <= '0;
              run_phase     <= PH_SETTLE;
              active_q      <= 1'b1;
            end
          end
        end
        SQ_RAMP: begin
          profile_speed <= sp_new[22:0];
        end
        SQ_CORR: begin
          active_q <= 1'b1;
          lsp_q    <= diff[24] ? sp24 + cm24 : sp24 - cm24;
          rsp_q    <= diff[24] ? sp24 - cm24 : sp24 + cm24;
        end
        default: begin
          active_q <= active_q;
        end
      endcase
    end
  end

  // result register, loaded as the sequencer leaves its last step
  always_ff @(posedge clk) begin
    if (seq == SQ_EMIT && res_free) begin
      res.drive_active       <= active_q;
      res.phase              <= run_phase;
      res.fault_code         <= fault_reg;
      res.left_speed_um_s    <= lsp_q;
      res.right_speed_um_s   <= rsp_q;
      res.left_total         <= left_sum;
      res.right_total        <= right_sum;
      res.left_measured_cpm  <= left_cpm_result;
      res.right_measured_cpm <= right_cpm_result;
      res.left_travel_mm     <= left_dist;
      res.right_travel_mm    <= right_dist;
    end
  end

  `ECPD_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "sequencer idle after a transaction was taken")
  `ECPD_ASSERT_NOW(a_active_phase, res_valid && res.drive_active, res.phase == PH_RUN || res.phase == PH_SETTLE, "drive active outside a run")
  `ECPD_ASSERT_NOW(a_idle_speeds, res_valid && !res.drive_active, res.left_speed_um_s == '0 && res.right_speed_um_s == '0, "speed given without drive")
  `ECPD_ASSERT_NOW(a_fault_done, res_valid && res.fault_code != FLT_NONE, res.phase == PH_DONE, "fault reported while run continues")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for encoder_calibration_profile_drive
// depends on ecpd_pkg and the block's rtl; holds its own predictor of the drive
module tb;
  import ecpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 2500000;
  localparam int          SETTLE_CYCLES = 200;   // longer than the slowest auto tick
  localparam logic [2:0]  MD_RSVD_FIRST = 3'd5;  // first undefined command code
  localparam logic [2:0]  MD_RSVD_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  encoder_calibration_profile_drive uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // register copy, written only while the block is idle
  int unsigned reg_val [8] = '{8000, 8000, 1000, 4000, 500, 500, 512, 6000};
  int unsigned reg_bits [8] = '{16, 16, 16, 16, 12, 14, 16, 16};

  // predicted drive state
  phase_t      run_ph;
  logic        run_auto;
  logic [31:0] lsum, rsum, lcpm, rcpm;
  longint      ldist, rdist, prof_speed;
  int unsigned still_n, elapsed_n;
  fault_t      run_fault;

  cmd_t pending_cmds [$];
  res_t expected_res [$];
  int   fails = 0;
  int   cycles = 0;
  logic cmd_took = 1'b0;
  int   send_gap = 0, stall_left = 0, hold_cnt = 0, hold_req = 0;
  bit   calm = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint count_mag(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - longint'(v)) : longint'(v);
  endfunction

  // rounded millimetres from a count, saturating at the 24-bit top
  function automatic longint travel_mm(logic [31:0] v, int unsigned cpm);
    longint c, d;
    c = (cpm == 0) ? 1 : cpm;
    d = (count_mag(v) * 2000 + c) / (2 * c);
    return (d > 24'hFFFFFF) ? 24'hFFFFFF : d;
  endfunction

  function automatic logic [31:0] measured_cpm(logic [31:0] v, int unsigned push_mm);
    longint d, r;
    d = (push_mm == 0) ? 1 : push_mm;
    r = (count_mag(v) * 1000 + d / 2) / d;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(r);
  endfunction

  function automatic longint root_floor(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return longint'(r);
  endfunction

  function automatic void clear_run();
    run_ph = PH_IDLE;  run_auto = 0;
    lsum = '0; rsum = '0; lcpm = '0; rcpm = '0;
    ldist = 0; rdist = 0; prof_speed = 0;
    still_n = 0; elapsed_n = 0; run_fault = FLT_NONE;
  endfunction

  function automatic void end_run(fault_t f);
    prof_speed = 0;
    run_fault = f;
    run_ph = PH_DONE;
  endfunction

  function automatic res_t drive_predict(cmd_t c);
    res_t r;
    longint ld, rd, lsp, rsp, s2, df, tgt, want, brk, stp, spd, cor, lim;
    bit act;
    ld = c.left_delta;
    rd = c.right_delta;
    lsp = 0; rsp = 0; act = 0;
    case (c.mode)
      MD_TICK: begin
        // accumulate first, then run the control step
        if (run_ph == PH_RUN || run_ph == PH_SETTLE) begin
          lsum = lsum - 32'(ld);
          rsum = rsum + 32'(rd);
          ldist = travel_mm(lsum, reg_val[RG_LEFT_CPM]);
          rdist = travel_mm(rsum, reg_val[RG_RIGHT_CPM]);
          if (run_auto && run_ph == PH_SETTLE) begin
            if (ld == 0 && rd == 0) begin
              if (still_n < 65535) still_n++;
              if (still_n >= STILL_TICKS) end_run(FLT_NONE);
            end else begin
              still_n = 0;
            end
          end
        end
        if (run_auto && (run_ph == PH_RUN || run_ph == PH_SETTLE)) begin
          if (elapsed_n < 65535) elapsed_n++;
          s2 = ldist + rdist;
          df = ldist - rdist;
          if (elapsed_n >= reg_val[RG_TIMEOUT]) begin
            end_run(FLT_TIMEOUT);
          end else if (s2 > MISMATCH_SUM_MM && (df < 0 ? -df : df) > MAX_MISMATCH_MM) begin
            end_run(FLT_MISMATCH);
          end else if (run_ph == PH_SETTLE) begin
            act = 1;
          end else begin
            tgt = reg_val[RG_AUTO_DIST];
            act = 1;
            if (s2 >= 2 * tgt - longint'(STOP_TOL_X2_MM)) begin
              prof_speed = 0;
              still_n = 0;
              run_ph = PH_SETTLE;
            end else begin
              brk = root_floor(longint'(reg_val[RG_ACCEL]) * (2 * tgt - s2) * 1000000);
              want = longint'(reg_val[RG_CRUISE]) * 1000;
              if (brk < want) want = brk;
              stp = longint'(reg_val[RG_ACCEL]) * 5;
              spd = prof_speed;
              if (spd < want - stp) spd += stp;
              else if (spd > want + stp) spd -= stp;
              else spd = want;
              prof_speed = spd;
              cor = (longint'(reg_val[RG_SYNC_GAIN]) * (df < 0 ? -df : df) * 1000 + 128) >>> 8;
              if (df < 0) cor = -cor;
              lim = spd / 2;
              if (lim > MAX_SYNC_CORR_UM_S) lim = MAX_SYNC_CORR_UM_S;
              if (cor < -lim) cor = -lim;
              if (cor > lim) cor = lim;
              lsp = spd - cor;
              rsp = spd + cor;
            end
          end
        end
      end
      MD_START_MAN, MD_START_AUTO: begin
        clear_run();
        run_auto = (c.mode == MD_START_AUTO);
        run_ph = PH_RUN;
      end
      MD_STOP_MAN: begin
        if (run_ph == PH_RUN) begin
          lcpm = measured_cpm(lsum, reg_val[RG_MAN_DIST]);
          rcpm = measured_cpm(rsum, reg_val[RG_MAN_DIST]);
          run_ph = PH_DONE;
        end
      end
      MD_STOP_AUTO: begin
        if (run_auto && (run_ph == PH_RUN || run_ph == PH_SETTLE)) end_run(FLT_NONE);
      end
      default: ;
    endcase
    r.drive_active       = act;
    r.phase              = run_ph;
    r.fault_code         = run_fault;
    r.left_speed_um_s    = 24'(lsp);
    r.right_speed_um_s   = 24'(rsp);
    r.left_total         = lsum;
    r.right_total        = rsum;
    r.left_measured_cpm  = lcpm;
    r.right_measured_cpm = rcpm;
    r.left_travel_mm     = 24'(ldist);
    r.right_travel_mm    = 24'(rdist);
    return r;
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  // every accepted command transaction is predicted at once
  always @(posedge clk) begin
    cmd_took <= cmd_valid && !cmd_stall;
    if (cmd_valid && !cmd_stall) expected_res.push_back(drive_predict(cmd));
  end

  // sender: one transaction at a time from the pending queue
  always @(negedge clk) begin
    logic nv;
    cmd_t nc;
    nv = cmd_valid;
    nc = cmd;
    if (!rst) begin
      if (cmd_valid && cmd_took) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          nc = pending_cmds.pop_front();
          nv = 1'b1;
          send_gap = pick_gap();
        end
      end
    end
    cmd_valid <= nv;
    cmd <= nc;
  end

  // receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    logic st;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      st = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      st = 1'b1;
    end else begin
      st = 1'b0;
      if ($urandom_range(3) == 0) stall_left = pick_gap();
    end
    res_stall <= st;
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) begin
        fails++;
        $display("%0t: result with nothing expected, actual %h", $time, res);
      end else begin
        e = expected_res.pop_front();
        check_field("drive_active", e.drive_active, res.drive_active);
        check_field("phase", e.phase, res.phase);
        check_field("fault_code", e.fault_code, res.fault_code);
        check_field("left_speed_um_s", e.left_speed_um_s, res.left_speed_um_s);
        check_field("right_speed_um_s", e.right_speed_um_s, res.right_speed_um_s);
        check_field("left_total", e.left_total, res.left_total);
        check_field("right_total", e.right_total, res.right_total);
        check_field("left_measured_cpm", e.left_measured_cpm, res.left_measured_cpm);
        check_field("right_measured_cpm", e.right_measured_cpm, res.right_measured_cpm);
        check_field("left_travel_mm", e.left_travel_mm, res.left_travel_mm);
        check_field("right_travel_mm", e.right_travel_mm, res.right_travel_mm);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_cmd(logic [2:0] m, logic signed [15:0] l, logic signed [15:0] r);
    cmd_t c;
    c.mode = m;
    c.left_delta = l;
    c.right_delta = r;
    pending_cmds.push_back(c);
  endtask

  // wait until every result is in, then give the sequencer time to go quiet
  task automatic wait_idle();
    wait (pending_cmds.size() == 0 && expected_res.size() == 0 && !cmd_valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    reg_val[idx] = val & ((1 << reg_bits[idx]) - 1);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // an auto run: drive forward, at times lopsided or with an early stop, then mostly hold still
  task automatic auto_run(ref int n);
    int moved, ticks, skew, cnt, stop_at;
    bit lopsided;
    push_cmd(MD_START_AUTO, 16'sd0, 16'sd0); n++;
    moved = 0; ticks = 0;
    lopsided = ($urandom_range(5) == 0);
    stop_at = ($urandom_range(7) == 0) ? $urandom_range(1, 30) : -1;
    while (moved < int'(reg_val[RG_AUTO_DIST]) + 10 && ticks < 80) begin
      skew = $urandom_range(10);
      cnt = $urandom_range(1, 25);
      moved += cnt;
      cnt = cnt * int'(reg_val[RG_LEFT_CPM]) / 1000 + 1;
      if (cnt > 30000) cnt = 30000;
      if (ticks == stop_at) begin
        push_cmd(MD_STOP_AUTO, 16'sd0, 16'sd0); n++;
      end
      push_cmd(MD_TICK, 16'(-cnt), 16'(lopsided ? 2 * cnt : cnt + skew - 5)); n++;
      ticks++;
    end
    repeat ($urandom_range(40, 46)) begin
      if ($urandom_range(15) == 0) push_cmd(MD_TICK, 16'($urandom_range(1, 9)), 16'sd0);
      else push_cmd(MD_TICK, 16'sd0, 16'sd0);
      n++;
    end
  endtask

  task automatic manual_run(ref int n);
    push_cmd(MD_START_MAN, 16'sd0, 16'sd0); n++;
    repeat ($urandom_range(1, 20)) begin
      push_cmd(MD_TICK, 16'(-$urandom_range(0, 4000)), 16'($urandom_range(0, 4000))); n++;
    end
    push_cmd(MD_STOP_MAN, 16'sd0, 16'sd0); n++;
    push_cmd(MD_TICK, 16'sd1, 16'sd1); n++;
  endtask

  task automatic noise(ref int n);
    repeat ($urandom_range(1, 6)) begin
      push_cmd(3'($urandom), 16'($urandom), 16'($urandom)); n++;
    end
  endtask

  task automatic random_config(int k);
    write_reg(RG_LEFT_CPM,  k == 1 ? 1 : (k == 2 ? 65535 : $urandom_range(500, 20000)));
    write_reg(RG_RIGHT_CPM, k == 1 ? 1 : (k == 2 ? 65535 : $urandom_range(500, 20000)));
    write_reg(RG_MAN_DIST,  k == 1 ? 1 : (k == 2 ? 65535 : $urandom_range(1, 65535)));
    write_reg(RG_AUTO_DIST, k == 1 ? 1 : (k == 2 ? 65535 : $urandom_range(5, 600)));
    write_reg(RG_CRUISE,    k == 1 ? 0 : (k == 2 ? 4000 : $urandom_range(0, 4000)));
    write_reg(RG_ACCEL,     k == 1 ? 0 : (k == 2 ? 10000 : $urandom_range(0, 10000)));
    write_reg(RG_SYNC_GAIN, k == 1 ? 0 : (k == 2 ? 65535 : $urandom_range(0, 65535)));
    write_reg(RG_TIMEOUT,   k == 1 ? 1 :
                            (k == 2 ? 65535 : ($urandom_range(4) == 0 ? $urandom_range(10, 120)
                                                                     : 65535)));
    end_writes();
  endtask

  initial begin
    int n;
    clear_run();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset values written explicitly, idle commands, extreme deltas
    write_reg(RG_LEFT_CPM, 8000);  write_reg(RG_RIGHT_CPM, 8000);
    write_reg(RG_MAN_DIST, 1000);  write_reg(RG_AUTO_DIST, 4000);
    write_reg(RG_CRUISE, 500);     write_reg(RG_ACCEL, 500);
    write_reg(RG_SYNC_GAIN, 512);  write_reg(RG_TIMEOUT, 6000);
    end_writes();
    push_cmd(MD_RSVD_FIRST, 16'sh8000, 16'sh7FFF);
    push_cmd(MD_RSVD_LAST, 16'sh7FFF, 16'sh8000);
    push_cmd(MD_TICK, 16'sd5, 16'sd5);         // tick while idle
    push_cmd(MD_STOP_MAN, 16'sd0, 16'sd0);     // stop manual outside a run
    push_cmd(MD_STOP_AUTO, 16'sd0, 16'sd0);    // stop auto outside a run
    push_cmd(MD_START_MAN, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, 16'sh8000, 16'sh7FFF);
    push_cmd(MD_TICK, 16'sh7FFF, 16'sh8000);
    push_cmd(MD_TICK, 16'shFFFF, 16'shFFFF);
    push_cmd(MD_STOP_AUTO, 16'sd0, 16'sd0);    // manual run ignores stop auto
    push_cmd(MD_STOP_MAN, 16'sd0, 16'sd0);
    push_cmd(MD_STOP_MAN, 16'sd0, 16'sd0);     // already done
    push_cmd(MD_START_AUTO, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, -16'sd800, 16'sd800);
    push_cmd(MD_STOP_MAN, 16'sd0, 16'sd0);     // honoured in auto mode too
    wait_idle();

    // target under the stop tolerance settles on the first tick
    write_reg(RG_AUTO_DIST, 5);
    end_writes();
    push_cmd(MD_START_AUTO, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, -16'sd3, 16'sd3);
    push_cmd(MD_STOP_AUTO, 16'sd0, 16'sd0);
    wait_idle();

    // zero timeout faults on the first control tick
    write_reg(RG_TIMEOUT, 0);
    end_writes();
    push_cmd(MD_START_AUTO, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, 16'sd0, 16'sd0);
    push_cmd(MD_TICK, 16'sd0, 16'sd0);
    wait_idle();

    // random phases, each under its own register setting
    for (int k = 1; k <= 10; k++) begin
      random_config(k);
      calm = (k % 4 == 0);
      // long receiver hold-off while the sender keeps offering
      if (k == 3) hold_req = 600;
      n = 0;
      while (n < 120) begin
        case ($urandom_range(9))
          0, 1:    manual_run(n);
          2:       noise(n);
          default: auto_run(n);
        endcase
      end
      // sender pauses until every result is back
      wait_idle();
    end
    calm = 0;

    wait_idle();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
